[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the bar width decoder modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold on every clock edge out of reset
`define SBWD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition must never be seen on a clock edge out of reset
`define SBWD_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define SBWD_ASSERT(lbl, clk, rstn, prop, msg)

`define SBWD_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

[rtl/sbwd_pkg.sv]
// ----------------------------------------------------------------------------
// sbwd_pkg
// shared types and constants of the scanline bar width decoder
// ----------------------------------------------------------------------------
package sbwd_pkg;

    localparam int MAX_LINE_BYTES = 2047;
    localparam int LOOKAHEAD      = 3;

    localparam int PIX_W = 8;
    localparam int RUN_W = 11;

    // run counter saturation point
    localparam int RUN_CAP_I = (MAX_LINE_BYTES < 2047) ? MAX_LINE_BYTES : 2047;
    localparam logic [RUN_W-1:0] RUN_CAP = RUN_W'(RUN_CAP_I);

    // register reset values
    localparam logic [PIX_W-1:0] DARK_RST   = 8'd100;
    localparam logic [PIX_W-1:0] NEAR_RST   = 8'd80;
    localparam logic [RUN_W-1:0] MINRUN_RST = 11'd10;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // result queue depth in entries (one entry per input byte with results)
    localparam int OQ_DEPTH_DFLT = 4;

    typedef enum logic [1:0] {
        REG_DARK   = 2'd0,
        REG_NEAR   = 2'd1,
        REG_MINRUN = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] dark_level;
        logic [PIX_W-1:0] near_dark_level;
        logic [RUN_W-1:0] min_run_length;
    } cfg_t;

    // results of one byte: one or two bits
    typedef struct packed {
        logic push;
        logic two;
        logic bit0;
        logic bit1;
    } res_t;

endpackage

[rtl/scanline_bar_width_decoder_top.sv]
// ----------------------------------------------------------------------------
// scanline_bar_width_decoder_top
// scanline bar width decoder: dark run lengths to narrow/wide bar bits
//
//  port group | dir | tdata / tuser / tlast          | meaning
//  s_*        | in  | tdata[7:0] pixel_byte, tlast  | scanline bytes, tlast = line_end
//  m_*        | out | tdata[0] bit_value, tlast     | decoded bits, tlast = last_of_run
//  apb        | cfg | 0x0 dark, 0x4 near-dark, 0x8 min run | threshold registers
//
//  one byte per cycle while the result queue has room; a byte goes through the input register and
//  its results are then written into the result queue
//  a byte giving two bits needs two output beats; the input stalls only when
//  the result queue holds more than OQ_DEPTH-2 entries
//  aresetn clears thresholds to their defaults and all line state; no
//  clearing pass, the block takes beats right after reset
// ----------------------------------------------------------------------------
module scanline_bar_width_decoder_top
    import sbwd_pkg::*;
#(
    parameter int OQ_DEPTH = OQ_DEPTH_DFLT
) (
    input  logic              aclk,
    input  logic              aresetn,

    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] pixel_byte
    input  logic              s_tlast,   // line_end

    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [0] bit_value, [7:1] zero
    output logic              m_tlast,   // last_of_run

    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    cfg_t cfg;
    res_t res;
    logic room;
    logic s_acc;
    logic m_bit;

    // input is taken while the queue can absorb the byte in flight and this one
    assign s_tready = room;
    assign s_acc    = s_tvalid && s_tready;

    sbwd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // window, run counter and bit decision
    sbwd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .in_acc  (s_acc),
        .in_pix  (s_tdata),
        .in_last (s_tlast),
        .res     (res)
    );

    // result queue, pairs are split into two beats
    sbwd_outq #(
        .DEPTH (OQ_DEPTH)
    ) u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .res     (res),
        .room    (room),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_bit   (m_bit),
        .m_last  (m_tlast)
    );

    assign m_tdata = {7'b0000000, m_bit};

endmodule

[rtl/sbwd_cfg.sv]
// ----------------------------------------------------------------------------
// sbwd_cfg
// apb register file: dark level, near-dark level, minimum run length
// ----------------------------------------------------------------------------
module sbwd_cfg
    import sbwd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_DARK:   cfg_next.dark_level      = pwdata[PIX_W-1:0];
                REG_NEAR:   cfg_next.near_dark_level = pwdata[PIX_W-1:0];
                REG_MINRUN: cfg_next.min_run_length  = pwdata[RUN_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_DARK:   prdata = APB_DW'(cfg_reg.dark_level);
            REG_NEAR:   prdata = APB_DW'(cfg_reg.near_dark_level);
            REG_MINRUN: prdata = APB_DW'(cfg_reg.min_run_length);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dark_level      <= DARK_RST;
            cfg_reg.near_dark_level <= NEAR_RST;
            cfg_reg.min_run_length  <= MINRUN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/sbwd_core.sv]
// ----------------------------------------------------------------------------
// sbwd_core
// input register, lookahead window, run counter and bit decision
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbwd_core
    import sbwd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             in_acc,
    input  logic [PIX_W-1:0] in_pix,
    input  logic             in_last,
    output res_t             res
);

    localparam logic [1:0] WIN_FULL = 2'(LOOKAHEAD);

    logic             in_vld_reg;
    logic [PIX_W-1:0] in_pix_reg;
    logic             in_last_reg;

    logic [PIX_W-1:0] win_reg [LOOKAHEAD];
    logic [PIX_W-1:0] win_next [LOOKAHEAD];
    logic [1:0]       fill_reg, fill_next;
    logic [RUN_W-1:0] run_len_reg, run_len_next;
    logic [RUN_W-1:0] ref_len_reg, ref_len_next;
    logic             have_ref_reg, have_ref_next;
    logic             run_active_reg, run_active_next;

    logic             full;
    logic             dark_full;
    logic [RUN_W-1:0] r1, r2, ref1;
    logic             a1, have1;
    logic             e1, e2;
    logic [1:0]       j1, j2;
    logic             v1, v2;

    function automatic logic [RUN_W-1:0] sat_inc(input logic [RUN_W-1:0] r);
        sat_inc = (r < RUN_CAP) ? r + 1'b1 : r;
    endfunction

    // {valid, bit} for a finished run against the reference
    function automatic logic [1:0] judge(input logic have, input logic [RUN_W-1:0] rl,
                                         input logic [RUN_W-1:0] r);
        logic [RUN_W+1:0] ref3;
        logic [RUN_W+1:0] r2x;
        logic [RUN_W+2:0] r5;
        ref3 = {2'b00, rl} + {1'b0, rl, 1'b0};
        r2x  = {1'b0, r, 1'b0};
        r5   = {3'b000, r} + {1'b0, r, 2'b00};
        if (!have) begin
            judge = 2'b10;
        end else if (r2x > ref3) begin
            judge = 2'b11;
        end else if (r5 >= {1'b0, ref3}) begin
            judge = 2'b10;
        end else begin
            judge = 2'b00;
        end
    endfunction

    always_comb begin
        full      = (fill_reg == WIN_FULL);
        dark_full = (win_reg[0] <= cfg.dark_level)
                 || (win_reg[1] <= cfg.near_dark_level)
                 || (win_reg[2] <= cfg.near_dark_level)
                 || (in_pix_reg <= cfg.near_dark_level);

        // decision on the oldest byte once the window is full
        r1 = run_len_reg;
        a1 = run_active_reg;
        e1 = 1'b0;
        if (full) begin
            if (dark_full) begin
                r1 = sat_inc(run_len_reg);
                a1 = 1'b1;
            end else begin
                a1 = 1'b0;
            end
            e1 = (r1 > cfg.min_run_length) && !a1;
        end
        // the ending run is judged at its full length before it clears
        j1    = judge(have_ref_reg, ref_len_reg, r1);
        v1    = e1 && j1[1];
        have1 = have_ref_reg || e1;
        ref1  = (e1 && !have_ref_reg) ? r1 : ref_len_reg;
        if (full && !a1) begin
            r1 = '0;
        end

        // window update
        for (int k = 0; k < LOOKAHEAD; k++) begin
            win_next[k] = win_reg[k];
        end
        fill_next = fill_reg;
        case (fill_reg)
            2'd0: begin
                win_next[0] = in_pix_reg;
                fill_next   = 2'd1;
            end
            2'd1: begin
                win_next[1] = in_pix_reg;
                fill_next   = 2'd2;
            end
            2'd2: begin
                win_next[2] = in_pix_reg;
                fill_next   = WIN_FULL;
            end
            default: begin
                win_next[0] = win_reg[1];
                win_next[1] = win_reg[2];
                win_next[2] = in_pix_reg;
            end
        endcase

        // line tail: remaining bytes decided without lookahead
        r2 = r1;
        for (int k = 0; k < LOOKAHEAD; k++) begin
            if (2'(k) < fill_next) begin
                if ((win_next[k] <= cfg.dark_level) || (r2 != '0)) begin
                    r2 = sat_inc(r2);
                end
            end
        end
        e2 = in_last_reg && (r2 > cfg.min_run_length);
        j2 = judge(have1, ref1, r2);
        v2 = e2 && j2[1];

        res.push = in_vld_reg && (v1 || v2);
        res.two  = v1 && v2;
        res.bit0 = v1 ? j1[0] : j2[0];
        res.bit1 = j2[0];

        // state update
        run_len_next    = run_len_reg;
        ref_len_next    = ref_len_reg;
        have_ref_next   = have_ref_reg;
        run_active_next = run_active_reg;
        if (in_vld_reg) begin
            if (in_last_reg) begin
                for (int k = 0; k < LOOKAHEAD; k++) begin
                    win_next[k] = '0;
                end
                fill_next       = 2'd0;
                run_len_next    = '0;
                ref_len_next    = '0;
                have_ref_next   = 1'b0;
                run_active_next = 1'b1;
            end else begin
                run_len_next    = r1;
                ref_len_next    = ref1;
                have_ref_next   = have1;
                run_active_next = a1;
            end
        end else begin
            for (int k = 0; k < LOOKAHEAD; k++) begin
                win_next[k] = win_reg[k];
            end
            fill_next = fill_reg;
        end
    end

    always_ff @(posedge aclk) begin
        in_pix_reg  <= in_pix;
        in_last_reg <= in_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg     <= 1'b0;
            fill_reg       <= 2'd0;
            run_len_reg    <= '0;
            ref_len_reg    <= '0;
            have_ref_reg   <= 1'b0;
            run_active_reg <= 1'b1;
            for (int k = 0; k < LOOKAHEAD; k++) begin
                win_reg[k] <= '0;
            end
        end else begin
            in_vld_reg     <= in_acc;
            fill_reg       <= fill_next;
            run_len_reg    <= run_len_next;
            ref_len_reg    <= ref_len_next;
            have_ref_reg   <= have_ref_next;
            run_active_reg <= run_active_next;
            for (int k = 0; k < LOOKAHEAD; k++) begin
                win_reg[k] <= win_next[k];
            end
        end
    end

    `SBWD_ASSERT(a_line_clears, aclk, aresetn, in_vld_reg && in_last_reg |=> fill_reg == 2'd0 && run_len_reg == '0, "line end left state behind")
    `SBWD_ASSERT(a_lit_no_run, aclk, aresetn, !run_active_reg |-> run_len_reg == '0, "run kept after lit byte")
    `SBWD_ASSERT(a_push_src, aclk, aresetn, res.push |-> fill_reg == WIN_FULL || in_last_reg, "result before window full")

endmodule

[rtl/sbwd_outq.sv]
// ----------------------------------------------------------------------------
// sbwd_outq
// result queue: one entry per byte with results, unpacked into beats
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbwd_outq
    import sbwd_pkg::*;
#(
    parameter int DEPTH = OQ_DEPTH_DFLT
) (
    input  logic aclk,
    input  logic aresetn,
    input  res_t res,
    output logic room,
    output logic m_valid,
    input  logic m_ready,
    output logic m_bit,
    output logic m_last
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ROOM = CNT_W'(DEPTH - 2);

    // entry: {two, bit0, bit1}
    logic [2:0]       ent_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             sub_reg, sub_next;
    logic [2:0]       head;
    logic             head_two;
    logic             beat;
    logic             pop;

    assign head     = ent_reg[rd_ptr_reg];
    assign head_two = head[2];
    assign m_valid  = (count_reg != '0);
    assign m_bit    = sub_reg ? head[0] : head[1];
    assign m_last   = !head_two || sub_reg;
    assign beat     = m_valid && m_ready;
    assign pop      = beat && m_last;
    // an item in the input register may still push one entry
    assign room     = (count_reg <= CNT_ROOM);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        sub_next    = sub_reg;
        if (res.push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (beat) begin
            sub_next = !m_last;
        end
        case ({res.push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (res.push) begin
            ent_reg[wr_ptr_reg] <= {res.two, res.bit0, res.bit1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sub_reg    <= sub_next;
        end
    end

    `SBWD_ASSERT(a_count_range, aclk, aresetn, count_reg <= CNT_FULL, "queue count out of range")
    `SBWD_NEVER(a_no_overflow, aclk, aresetn, res.push && count_reg == CNT_FULL && !pop, "push into full queue")
    `SBWD_ASSERT(a_sub_two, aclk, aresetn, sub_reg |-> m_valid && head_two, "second beat without pair entry")

endmodule
